/* hw/rtl/sel_pkg.sv */
package sel_pkg;

  // config register indexes
  localparam logic [2:0] RegRangeCount = 3'd0;
  localparam logic [2:0] RegCount0     = 3'd1;
  localparam logic [2:0] RegCount1     = 3'd2;
  localparam logic [2:0] RegCount2     = 3'd3;
  localparam logic [2:0] RegError1     = 3'd4;
  localparam logic [2:0] RegError2     = 3'd5;
  localparam logic [2:0] RegNearPlane  = 3'd6;
  localparam logic [2:0] RegMaxPixErr  = 3'd7;

  localparam int unsigned LEVELS = 3;

  localparam logic [16:0] MaxPixErrOne = 17'd65536;
  localparam logic        StatusOk     = 1'b0;
  localparam logic        StatusInval  = 1'b1;

  // control that travels with each word
  typedef struct packed {
    logic vld;
    logic bad;
    logic near_ok;
  } ctl_t;

endpackage

/* hw/rtl/sel_wmul.sv */
module sel_wmul import sel_pkg::*; (
  input  logic         clk_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);

  logic [63:0]  pp0_q, pp1_q, pp2_q, pp3_q;
  logic [127:0] p_q;

  // stage 1: four 32x32 partial products
  always_ff @(posedge clk_i) begin
    pp0_q <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
    pp1_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
    pp2_q <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
    pp3_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
  end

  // stage 2: align and add
  always_ff @(posedge clk_i) begin
    p_q <= {64'd0, pp0_q} + {32'd0, pp1_q, 32'd0} + {32'd0, pp2_q, 32'd0}
         + {pp3_q, 64'd0};
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/screen_error_lod_select.sv */
// Screen-space error LOD select. A query word is taken at every clock edge
// with start high (busy is always low), so one query per cycle is
// sustained. The result appears on the output ports with done high for
// exactly one cycle, after the query has passed through the pipeline: input
// decode, scale multipliers, error/room compare, two stages of split 64x64
// cross products, and the final compare and select.
// The receiver cannot stall. Config writes (cfg_we_i, cfg_idx_i, cfg_data_i)
// take effect at once and must only be made while no query is in flight.
module screen_error_lod_select import sel_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic signed [31:0] radius_i,
  input  logic signed [31:0] pixels_x_i,
  input  logic signed [31:0] pixels_y_i,
  input  logic signed [31:0] max_scale_i,
  input  logic               tight_bounds_i,
  input  logic signed [31:0] max_abs_x_i,
  input  logic signed [31:0] max_abs_y_i,
  input  logic signed [31:0] min_depth_i,
  output logic               done,
  output logic               status_o,
  output logic [21:0]        index_count_o,
  output logic [22:0]        first_index_o,
  output logic [1:0]         level_o
);

  // ---------------- config registers ----------------
  logic [1:0]  range_q;
  logic [21:0] cnt0_q, cnt1_q, cnt2_q;
  logic [30:0] err1_q, err2_q, near_q;
  logic [16:0] mpe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= '0;
      cnt0_q  <= '0;
      cnt1_q  <= '0;
      cnt2_q  <= '0;
      err1_q  <= '0;
      err2_q  <= '0;
      near_q  <= 31'd6554;
      mpe_q   <= MaxPixErrOne;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRangeCount: range_q <= cfg_data_i[1:0];
        RegCount0:     cnt0_q  <= cfg_data_i[21:0];
        RegCount1:     cnt1_q  <= cfg_data_i[21:0];
        RegCount2:     cnt2_q  <= cfg_data_i[21:0];
        RegError1:     err1_q  <= cfg_data_i;
        RegError2:     err2_q  <= cfg_data_i;
        RegNearPlane:  near_q  <= cfg_data_i;
        RegMaxPixErr:  mpe_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start & ~busy;

  // ---------------- stage A: decode ----------------
  logic              bad_a;
  logic signed [32:0] nz_a;
  logic [31:0]       abs_x, abs_y;
  logic [32:0]       lx_a, ly_a;
  logic              near_ok_a;

  always_comb begin
    bad_a = (range_q < 2'd2) || (radius_i <= 0) || (pixels_x_i <= 0) ||
            (pixels_y_i <= 0) || (max_scale_i <= 0) || (near_q == '0) ||
            (mpe_q == '0) || (mpe_q > MaxPixErrOne) ||
            (tight_bounds_i && (max_abs_x_i[31] || max_abs_y_i[31]));
    abs_x = center_x_i[31] ? (~center_x_i + 32'd1) : center_x_i;
    abs_y = center_y_i[31] ? (~center_y_i + 32'd1) : center_y_i;
    if (tight_bounds_i) begin
      nz_a = {min_depth_i[31], min_depth_i};
      lx_a = {1'b0, max_abs_x_i};
      ly_a = {1'b0, max_abs_y_i};
    end else begin
      nz_a = {center_z_i[31], center_z_i} - {radius_i[31], radius_i};
      lx_a = {1'b0, abs_x} + {2'b0, radius_i[30:0]};
      ly_a = {1'b0, abs_y} + {2'b0, radius_i[30:0]};
    end
    near_ok_a = nz_a > $signed({2'b00, near_q});
  end

  ctl_t        ca_q;
  logic [30:0] nz_aq, ms_aq, px_aq, py_aq;
  logic [32:0] lx_aq, ly_aq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ca_q <= '0;
    else         ca_q <= '{vld: acc, bad: bad_a, near_ok: near_ok_a};
  end

  always_ff @(posedge clk_i) begin
    nz_aq <= nz_a[30:0];
    ms_aq <= max_scale_i[30:0];
    px_aq <= pixels_x_i[30:0];
    py_aq <= pixels_y_i[30:0];
    lx_aq <= lx_a;
    ly_aq <= ly_a;
  end

  // ---------------- stage B: scale products ----------------
  ctl_t        cb_q;
  logic [30:0] nz_bq;
  logic [61:0] e1_bq, e2_bq;
  logic [63:0] ax_bq, ay_bq;
  logic [51:0] rhs_bq;
  logic [20:0] mpe9;

  assign mpe9 = {1'b0, mpe_q, 3'b000} + {4'd0, mpe_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cb_q <= '0;
    else         cb_q <= ca_q;
  end

  always_ff @(posedge clk_i) begin
    nz_bq  <= nz_aq;
    e1_bq  <= 62'(err1_q) * 62'(ms_aq);
    e2_bq  <= 62'(err2_q) * 62'(ms_aq);
    ax_bq  <= 64'(px_aq) * (64'(nz_aq) + 64'(lx_aq));
    ay_bq  <= 64'(py_aq) * (64'(nz_aq) + 64'(ly_aq));
    rhs_bq <= 52'(mpe9) * 52'(nz_aq);
  end

  // ---------------- stage C: room check, safe depth ----------------
  logic [30:0] diff_b;
  logic [61:0] room_b;

  assign diff_b = nz_bq - near_q;
  assign room_b = {15'd0, diff_b, 16'd0};

  ctl_t        cc_q;
  logic        ok1_cq, ok2_cq;
  logic [46:0] safe1_cq, safe2_cq;
  logic [50:0] m1_cq, m2_cq;
  logic [63:0] ax_cq, ay_cq;
  logic [51:0] rhs_cq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cc_q <= '0;
    else         cc_q <= cb_q;
  end

  always_ff @(posedge clk_i) begin
    ok1_cq   <= e1_bq < room_b;
    ok2_cq   <= e2_bq < room_b;
    safe1_cq <= {nz_bq, 16'd0} - e1_bq[46:0];
    safe2_cq <= {nz_bq, 16'd0} - e2_bq[46:0];
    // err * 10 as shifted adds; err < 2^47 whenever it matters
    m1_cq    <= {1'b0, e1_bq[46:0], 3'b000} + {3'b000, e1_bq[46:0], 1'b0};
    m2_cq    <= {1'b0, e2_bq[46:0], 3'b000} + {3'b000, e2_bq[46:0], 1'b0};
    ax_cq    <= ax_bq;
    ay_cq    <= ay_bq;
    rhs_cq   <= rhs_bq;
  end

  // ---------------- stages D, E: cross products ----------------
  logic [127:0] lx1, ly1, r1, lx2, ly2, r2;

  sel_wmul u_mx1 (.clk_i, .a_i(ax_cq), .b_i({13'd0, m1_cq}), .p_o(lx1));
  sel_wmul u_my1 (.clk_i, .a_i(ay_cq), .b_i({13'd0, m1_cq}), .p_o(ly1));
  sel_wmul u_mr1 (.clk_i, .a_i({12'd0, rhs_cq}), .b_i({17'd0, safe1_cq}), .p_o(r1));
  sel_wmul u_mx2 (.clk_i, .a_i(ax_cq), .b_i({13'd0, m2_cq}), .p_o(lx2));
  sel_wmul u_my2 (.clk_i, .a_i(ay_cq), .b_i({13'd0, m2_cq}), .p_o(ly2));
  sel_wmul u_mr2 (.clk_i, .a_i({12'd0, rhs_cq}), .b_i({17'd0, safe2_cq}), .p_o(r2));

  ctl_t cd_q, ce_q;
  logic ok1_dq, ok2_dq, ok1_eq, ok2_eq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q <= '0;
      ce_q <= '0;
    end else begin
      cd_q <= cc_q;
      ce_q <= cd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok1_dq       <= ok1_cq;
    ok2_dq       <= ok2_cq;
    ok1_eq       <= ok1_dq;
    ok2_eq       <= ok2_dq;
  end

  // ---------------- stage F: compare and select ----------------
  logic       pass1, pass2, use2;
  logic [1:0] sel;

  always_comb begin
    pass1 = ok1_eq && (lx1 <= r1) && (ly1 <= r1);
    pass2 = ok2_eq && (lx2 <= r2) && (ly2 <= r2);
    use2  = (LEVELS > 2) && (range_q == 2'd3);
    if (!ce_q.near_ok)      sel = 2'd0;
    else if (use2 && pass2) sel = 2'd2;
    else if (pass1)         sel = 2'd1;
    else                    sel = 2'd0;
  end

  logic        done_q, st_q;
  logic [21:0] cnt_q;
  logic [22:0] first_q;
  logic [1:0]  lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= ce_q.vld;
  end

  always_ff @(posedge clk_i) begin
    if (ce_q.bad) begin
      st_q    <= StatusInval;
      cnt_q   <= '0;
      first_q <= '0;
      lvl_q   <= '0;
    end else begin
      st_q  <= StatusOk;
      lvl_q <= sel;
      case (sel)
        2'd1: begin
          cnt_q   <= cnt1_q;
          first_q <= {1'b0, cnt0_q};
        end
        2'd2: begin
          cnt_q   <= cnt2_q;
          first_q <= {1'b0, cnt0_q} + {1'b0, cnt1_q};
        end
        default: begin
          cnt_q   <= cnt0_q;
          first_q <= '0;
        end
      endcase
    end
  end

  assign done          = done_q;
  assign status_o      = st_q;
  assign index_count_o = cnt_q;
  assign first_index_o = first_q;
  assign level_o       = lvl_q;

  // ---------------- assertions ----------------
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##6 done)
    else $error("result did not follow query");

  a_nolat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(acc, 6))
    else $error("result without query");

  a_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && status_o) |-> (index_count_o == '0 && first_index_o == '0 && level_o == '0))
    else $error("invalid result fields not zero");

  a_lvl0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !status_o && level_o == 2'd0) |-> first_index_o == '0)
    else $error("level 0 with nonzero first index");

endmodule

/* sim/screen_error_lod_select_tb.sv */
`timescale 1ns / 1ps

module screen_error_lod_select_tb;
  import sel_pkg::*;

  // clock, reset, handshake
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = RegRangeCount;
  logic [30:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  logic done;

  // query word fields
  logic signed [31:0] center_x_i = '0, center_y_i = '0, center_z_i = '0, radius_i = '0;
  logic signed [31:0] pixels_x_i = '0, pixels_y_i = '0, max_scale_i = '0;
  logic tight_bounds_i = 1'b0;
  logic signed [31:0] max_abs_x_i = '0, max_abs_y_i = '0, min_depth_i = '0;

  // result word
  logic status_o;
  logic [21:0] index_count_o;
  logic [22:0] first_index_o;
  logic [1:0] level_o;

  typedef struct packed {
    logic signed [31:0] cx, cy, cz, r, px, py, ms;
    logic tight;
    logic signed [31:0] tx, ty, tz;
  } query_t;

  typedef struct packed {
    logic status;
    logic [21:0] cnt;
    logic [22:0] first;
    logic [1:0] lvl;
  } lod_t;

  // directed row: a query plus an optional typed-in result
  typedef struct packed {
    query_t q;
    logic has_lit;
    lod_t lit;
  } row_t;

  localparam int DrainCycles = 12;
  localparam int CycleLimit = 200000;

  screen_error_lod_select dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the register file
  logic [1:0] range_q;
  logic [21:0] count_q [3];
  logic [30:0] error_q [3];
  logic [30:0] near_q;
  logic [16:0] mpe_q;

  lod_t lod_queue [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;   // stretch with no idling

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // exact a*b <= c*d on 64-bit operands
  function automatic bit prod_le(input logic [63:0] a, b, c, d);
    logic [127:0] l, rr;
    l = {64'd0, a} * {64'd0, b};
    rr = {64'd0, c} * {64'd0, d};
    return l <= rr;
  endfunction

  function automatic lod_t pick_lod(input query_t q);
    lod_t res;
    logic [1:0] eff, sel;
    logic signed [63:0] nz, lx, ly;
    logic [63:0] unz, room, err, safe, rhs, first;
    bit okx, oky;
    res = '0;
    eff = (range_q > LEVELS) ? 2'(LEVELS) : range_q;
    sel = 0;
    first = 0;
    if (eff < 2 || q.r <= 0 || q.px <= 0 || q.py <= 0 || q.ms <= 0 || near_q == 0 ||
        mpe_q == 0 || mpe_q > MaxPixErrOne || (q.tight && (q.tx < 0 || q.ty < 0))) begin
      res.status = StatusInval;
      return res;
    end
    nz = q.tight ? 64'(q.tz) : 64'(q.cz) - 64'(q.r);
    if (nz > $signed({33'd0, near_q})) begin
      unz = nz;
      room = 64'(nz - $signed({33'd0, near_q})) << 16;
      lx = q.tight ? 64'(q.tx) : ((q.cx < 0) ? -64'(q.cx) : 64'(q.cx)) + 64'(q.r);
      ly = q.tight ? 64'(q.ty) : ((q.cy < 0) ? -64'(q.cy) : 64'(q.cy)) + 64'(q.r);
      for (int l = 1; l < eff; l++) begin
        err = {33'd0, error_q[l]} * {32'd0, q.ms};
        if (err >= room) continue;
        safe = (unz << 16) - err;
        rhs = 64'd9 * {47'd0, mpe_q} * unz;
        okx = prod_le(64'(q.px) * (unz + lx), err * 10, rhs, safe);
        oky = prod_le(64'(q.py) * (unz + ly), err * 10, rhs, safe);
        if (okx && oky) sel = 2'(l);
      end
    end
    for (int l = 0; l < sel; l++) first = first + 64'(count_q[l]);
    res.status = StatusOk;
    res.cnt = count_q[sel];
    res.first = first[22:0];
    res.lvl = sel;
    return res;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegRangeCount: range_q = val[1:0];
      RegCount0:     count_q[0] = val[21:0];
      RegCount1:     count_q[1] = val[21:0];
      RegCount2:     count_q[2] = val[21:0];
      RegError1:     error_q[1] = val;
      RegError2:     error_q[2] = val;
      RegNearPlane:  near_q = val;
      RegMaxPixErr:  mpe_q = val[16:0];
      default: ;
    endcase
  endtask

  // drop start, wait for every expected word, then let the pipe drain
  task automatic drain();
    start <= 1'b0;
    wait (lod_queue.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // drive one query; called at a falling edge, returns at a falling edge
  // with start still high, so queries can follow back to back
  task automatic send(input query_t q, input bit has_lit, input lod_t lit);
    while (!quiet && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    {center_x_i, center_y_i, center_z_i, radius_i, pixels_x_i, pixels_y_i, max_scale_i,
     tight_bounds_i, max_abs_x_i, max_abs_y_i, min_depth_i} <= q;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    lod_queue.push_back(has_lit ? lit : pick_lod(q));
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1 << 20);
      2: return $urandom_range(1 << 24, 1);
      3: return -$signed(32'($urandom_range(1 << 18)));
      default: return $urandom_range(1 << 22, 1 << 14);
    endcase
  endfunction

  // mostly valid queries with a realistic depth, some noise
  function automatic query_t rnd_query();
    query_t q;
    q.cx = rnd_val(); q.cy = rnd_val();
    q.cz = $urandom_range(16) == 0 ? 32'($urandom) : 32'($urandom_range(1 << 26, 1 << 16));
    q.r = $urandom_range(20) == 0 ? rnd_val() : 32'($urandom_range(1 << 18, 1));
    q.px = $urandom_range(20) == 0 ? rnd_val() : 32'($urandom_range(1 << 27, 1 << 10));
    q.py = $urandom_range(20) == 0 ? rnd_val() : 32'($urandom_range(1 << 27, 1 << 10));
    q.ms = $urandom_range(20) == 0 ? rnd_val() : 32'($urandom_range(1 << 18, 1 << 12));
    q.tight = 1'($urandom_range(1));
    q.tx = $urandom_range(16) == 0 ? rnd_val() : 32'($urandom_range(1 << 24));
    q.ty = $urandom_range(16) == 0 ? rnd_val() : 32'($urandom_range(1 << 24));
    q.tz = $urandom_range(16) == 0 ? 32'($urandom) : 32'($urandom_range(1 << 26, 1 << 16));
    return q;
  endfunction

  // result checker: done words sampled at the rising edge
  always @(posedge clk_i) begin
    lod_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && done) begin
      if (lod_queue.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        want = lod_queue.pop_front();
        if (status_o !== want.status) report("status", status_o, want.status);
        if (index_count_o !== want.cnt) report("index_count", index_count_o, want.cnt);
        if (first_index_o !== want.first) report("first_index", first_index_o, want.first);
        if (level_o !== want.lvl) report("level", level_o, want.lvl);
      end
    end
  end

  query_t base;
  row_t rows [$];
  row_t row;
  lod_t inval;

  initial begin
    range_q = 0; count_q = '{0, 0, 0}; error_q = '{0, 0, 0};
    near_q = 6554; mpe_q = MaxPixErrOne;
    inval = '{status: StatusInval, cnt: 0, first: 0, lvl: 0};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // a plain valid sphere query far from the camera
    base = '{cx: 32'sh10000, cy: -32'sh10000, cz: 32'sh100000, r: 32'sh8000,
             px: 32'sh100000, py: 32'sh100000, ms: 32'sh10000, tight: 0,
             tx: 0, ty: 0, tz: 0};

    // after reset: range count zero, every query is invalid
    send(base, 1, inval);
    drain();

    write_reg(RegRangeCount, 31'd3);
    write_reg(RegCount0, 31'h300000);
    write_reg(RegCount1, 31'h300000);
    write_reg(RegCount2, 31'h100);
    write_reg(RegError1, 31'h100);
    write_reg(RegError2, 31'h10000);
    write_reg(RegNearPlane, 31'd6554);
    write_reg(RegMaxPixErr, 31'(MaxPixErrOne));

    rows.push_back('{base, 0, '0});
    row = '{base, 1, inval}; row.q.r = 0; rows.push_back(row);
    row = '{base, 1, inval}; row.q.r = 32'sh80000000; rows.push_back(row);
    row = '{base, 1, inval}; row.q.px = 0; rows.push_back(row);
    row = '{base, 1, inval}; row.q.py = -1; rows.push_back(row);
    row = '{base, 1, inval}; row.q.ms = 0; rows.push_back(row);
    row = '{base, 1, inval}; row.q.tight = 1; row.q.tx = -1; rows.push_back(row);
    row = '{base, 1, inval}; row.q.tight = 1; row.q.ty = 32'sh80000000; rows.push_back(row);
    row = '{base, 0, '0}; row.q.tight = 1; row.q.tx = 32'sh7fffffff;
    row.q.ty = 0; row.q.tz = 32'sh7fffffff; rows.push_back(row);
    // object at or before the near plane: level 0
    row = '{base, 1, '{StatusOk, 22'h300000, 23'd0, 2'd0}}; row.q.cz = 32'sh8000;
    rows.push_back(row);
    row = '{base, 1, '{StatusOk, 22'h300000, 23'd0, 2'd0}}; row.q.tight = 1;
    row.q.tz = 6554; rows.push_back(row);
    row = '{base, 0, '0}; row.q.cx = 32'sh80000000; row.q.cy = 32'sh7fffffff;
    rows.push_back(row);
    row = '{base, 0, '0}; row.q.cz = 32'sh7fffffff; row.q.px = 32'sh7fffffff;
    row.q.py = 1; row.q.ms = 32'sh7fffffff; row.q.r = 32'sh7fffffff; rows.push_back(row);
    row = '{base, 0, '0}; row.q.cz = 32'sh7fffffff; row.q.r = 1; row.q.px = 1;
    row.q.py = 1; row.q.ms = 1; rows.push_back(row);   // far: coarsest, sum fits 23 bits
    foreach (rows[i]) send(rows[i].q, rows[i].has_lit, rows[i].lit);
    drain();

    // near plane zero, pixel error zero / over one and range count one are invalid
    write_reg(RegNearPlane, 31'd0);
    send(base, 1, inval);
    drain();
    write_reg(RegNearPlane, 31'h7fffffff);
    write_reg(RegMaxPixErr, 31'd0);
    send(base, 1, inval);
    drain();
    write_reg(RegMaxPixErr, 31'h1ffff);
    send(base, 1, inval);
    drain();
    write_reg(RegMaxPixErr, 31'(MaxPixErrOne));
    write_reg(RegRangeCount, 31'd1);
    send(base, 1, inval);
    drain();

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(RegRangeCount, ph == 0 ? 31'd3 : 31'($urandom_range(3)));
      write_reg(RegCount0, ph == 1 ? 31'h3fffff : 31'($urandom_range(3145728)));
      write_reg(RegCount1, 31'($urandom_range(3145728)));
      write_reg(RegCount2, ph == 2 ? 31'd0 : 31'($urandom_range(3145728)));
      write_reg(RegError1, ph == 3 ? 31'h7fffffff : 31'($urandom_range(1 << 16)));
      write_reg(RegError2, ph == 4 ? 31'd0 : 31'($urandom_range(1 << 20)));
      write_reg(RegNearPlane, ph == 5 ? 31'd1 : 31'($urandom_range(1 << 18, 1)));
      write_reg(RegMaxPixErr, ph == 6 ? 31'd1 : 31'($urandom_range(65536)));
      quiet = (ph == 7);
      for (int n = 0; n < 150; n++) send(rnd_query(), 0, '0);
      quiet = 0;
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sel_pkg.sv
hw/rtl/sel_wmul.sv
hw/rtl/screen_error_lod_select.sv
sim/screen_error_lod_select_tb.sv
